FILE: design/stt_pkg.sv
package stt_pkg;

	localparam int CH_BITS     = 8;
	localparam int KIND_BITS   = 4;
	localparam int LINE_W      = 16;
	localparam int COLUMN_W    = 16;
	localparam int OFFSET_W    = 24;
	localparam int LENGTH_W    = 16;
	localparam int PREFIX_BITS = 40;

	localparam int IN_DEPTH  = 2;
	localparam int OUT_DEPTH = 4;

	localparam logic [KIND_BITS-1:0] KIND_IDENT   = 4'd0;
	localparam logic [KIND_BITS-1:0] KIND_INT     = 4'd1;
	localparam logic [KIND_BITS-1:0] KIND_FLOAT   = 4'd2;
	localparam logic [KIND_BITS-1:0] KIND_KEYWORD = 4'd3;
	localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 4'd4;
	localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 4'd5;
	localparam logic [KIND_BITS-1:0] KIND_LBRACE  = 4'd6;
	localparam logic [KIND_BITS-1:0] KIND_RBRACE  = 4'd7;
	localparam logic [KIND_BITS-1:0] KIND_LBRACK  = 4'd8;
	localparam logic [KIND_BITS-1:0] KIND_RBRACK  = 4'd9;
	localparam logic [KIND_BITS-1:0] KIND_SEMI    = 4'd10;
	localparam logic [KIND_BITS-1:0] KIND_ERROR   = 4'd11;

	localparam logic [CH_BITS-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [CH_BITS-1:0] CH_TAB     = 8'h09;
	localparam logic [CH_BITS-1:0] CH_SPACE   = 8'h20;
	localparam logic [CH_BITS-1:0] CH_HASH    = 8'h23;
	localparam logic [CH_BITS-1:0] CH_DOT     = 8'h2E;

	// "int" and "float", first byte highest
	localparam logic [PREFIX_BITS-1:0] WORD_INT   = 40'h00_0069_6E74;
	localparam logic [PREFIX_BITS-1:0] WORD_FLOAT = 40'h66_6C6F_6174;

	typedef enum logic [2:0] {
		CLS_SKIP    = 3'd0,
		CLS_NEWLINE = 3'd1,
		CLS_HASH    = 3'd2,
		CLS_LETTER  = 3'd3,
		CLS_DIGIT   = 3'd4,
		CLS_DOT     = 3'd5,
		CLS_BRACKET = 3'd6
	} char_class_t;

	typedef struct packed {
		char_class_t          cls;
		logic [CH_BITS-1:0]   ch;
		logic [KIND_BITS-1:0] bkind;
		logic                 last;
	} item_t;

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [LINE_W-1:0]    line;
		logic [COLUMN_W-1:0]  column;
		logic [OFFSET_W-1:0]  offset;
		logic [LENGTH_W-1:0]  length;
		logic                 last_of_run;
	} token_t;

	// result writes from the back end into the result queue
	typedef struct packed {
		logic [1:0] count;
		token_t     tok0;
		token_t     tok1;
	} res_wr_t;

endpackage

FILE: design/stt_front.sv
module stt_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [stt_pkg::CH_BITS-1:0]      ch,
	input  logic                             end_of_source,
	output logic                             item_valid,
	output stt_pkg::item_t                   item,
	input  logic                             item_take
);

	localparam int PTR_W = $clog2(stt_pkg::IN_DEPTH);
	localparam int CNT_W = $clog2(stt_pkg::IN_DEPTH + 1);

	stt_pkg::item_t  slot_q [stt_pkg::IN_DEPTH];
	stt_pkg::item_t  cls_item;
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	always_comb begin
		cls_item.ch    = ch;
		cls_item.last  = end_of_source;
		cls_item.bkind = stt_pkg::KIND_IDENT;
		cls_item.cls   = stt_pkg::CLS_SKIP;
		case (ch) inside
			stt_pkg::CH_NEWLINE: cls_item.cls = stt_pkg::CLS_NEWLINE;
			stt_pkg::CH_HASH:    cls_item.cls = stt_pkg::CLS_HASH;
			stt_pkg::CH_DOT:     cls_item.cls = stt_pkg::CLS_DOT;
			stt_pkg::CH_SPACE, stt_pkg::CH_TAB: cls_item.cls = stt_pkg::CLS_SKIP;
			[8'h61:8'h7A], [8'h41:8'h5A]: cls_item.cls = stt_pkg::CLS_LETTER;
			[8'h30:8'h39]: cls_item.cls = stt_pkg::CLS_DIGIT;
			8'h28: begin
				cls_item.cls   = stt_pkg::CLS_BRACKET;
				cls_item.bkind = stt_pkg::KIND_LPAREN;
			end
			8'h29: begin
				cls_item.cls   = stt_pkg::CLS_BRACKET;
				cls_item.bkind = stt_pkg::KIND_RPAREN;
			end
			8'h7B: begin
				cls_item.cls   = stt_pkg::CLS_BRACKET;
				cls_item.bkind = stt_pkg::KIND_LBRACE;
			end
			8'h7D: begin
				cls_item.cls   = stt_pkg::CLS_BRACKET;
				cls_item.bkind = stt_pkg::KIND_RBRACE;
			end
			8'h5B: begin
				cls_item.cls   = stt_pkg::CLS_BRACKET;
				cls_item.bkind = stt_pkg::KIND_LBRACK;
			end
			8'h5D: begin
				cls_item.cls   = stt_pkg::CLS_BRACKET;
				cls_item.bkind = stt_pkg::KIND_RBRACK;
			end
			8'h3B: begin
				cls_item.cls   = stt_pkg::CLS_BRACKET;
				cls_item.bkind = stt_pkg::KIND_SEMI;
			end
			default: cls_item.cls = stt_pkg::CLS_SKIP;
		endcase
	end

	assign full       = (cnt_q == CNT_W'(stt_pkg::IN_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign item       = slot_q[rp_q];
	assign do_push    = push && !full;
	assign do_pop     = item_take && item_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wp_q] <= cls_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/stt_back.sv
module stt_back #(
	parameter int LINE_BITS   = 16,
	parameter int COLUMN_BITS = 16,
	parameter int OFFSET_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  stt_pkg::item_t    item,
	output logic              item_take,
	input  logic              room,
	output stt_pkg::res_wr_t  wr
);

	typedef enum logic [4:0] {
		MODE_IDLE    = 5'b00001,
		MODE_IDENT   = 5'b00010,
		MODE_NUMBER  = 5'b00100,
		MODE_COMMENT = 5'b01000,
		MODE_HALTED  = 5'b10000
	} mode_t;

	localparam int LEN_W = stt_pkg::LENGTH_W;
	localparam int PFX_W = stt_pkg::PREFIX_BITS;

	mode_t                  mode_q, mode_d;
	logic                   seen_q, seen_d;
	logic [LINE_BITS-1:0]   line_q, line_d;
	logic [COLUMN_BITS-1:0] col_q, col_d;
	logic [OFFSET_BITS-1:0] byte_q, byte_d;
	logic [COLUMN_BITS-1:0] scol_q, scol_d;
	logic [OFFSET_BITS-1:0] soff_q, soff_d;
	logic [LEN_W-1:0]       len_q, len_d;
	logic [PFX_W-1:0]       pfx_q, pfx_d;

	logic                   fire;
	logic                   nl;
	logic                   as_idle;
	logic                   start_ident;
	logic                   start_number;
	logic [LEN_W-1:0]       ext_len;
	logic [PFX_W-1:0]       ext_pfx;

	logic                          emit_a, emit_b;
	logic [stt_pkg::KIND_BITS-1:0] a_kind, b_kind;
	logic [COLUMN_BITS-1:0]        a_col, b_col;
	logic [OFFSET_BITS-1:0]        a_off, b_off;
	logic [LEN_W-1:0]              a_len, b_len;
	logic [31:0]                   line_w;
	logic [31:0]                   a_col_w, b_col_w;
	logic [47:0]                   a_off_w, b_off_w;

	function automatic logic [stt_pkg::KIND_BITS-1:0] run_kind(
		input mode_t            m,
		input logic [LEN_W-1:0] n,
		input logic [PFX_W-1:0] p,
		input logic             s
	);
		logic [stt_pkg::KIND_BITS-1:0] k;
		if (m == MODE_IDENT) begin
			k = stt_pkg::KIND_IDENT;
			if ((n == LEN_W'(3) && p == stt_pkg::WORD_INT) ||
			    (n == LEN_W'(5) && p == stt_pkg::WORD_FLOAT)) begin
				k = stt_pkg::KIND_KEYWORD;
			end
		end else begin
			k = s ? stt_pkg::KIND_FLOAT : stt_pkg::KIND_INT;
		end
		return k;
	endfunction

	assign fire      = item_valid && room;
	assign item_take = room;
	assign ext_len   = (&len_q) ? len_q : len_q + 1'b1;
	assign ext_pfx   = (len_q < LEN_W'(5)) ? {pfx_q[PFX_W-9:0], item.ch} : pfx_q;

	always_comb begin
		mode_d = mode_q;
		seen_d = seen_q;
		scol_d = scol_q;
		soff_d = soff_q;
		len_d  = len_q;
		pfx_d  = pfx_q;
		nl           = 1'b0;
		as_idle      = 1'b0;
		start_ident  = 1'b0;
		start_number = 1'b0;
		emit_a = 1'b0;
		a_kind = run_kind(mode_q, len_q, pfx_q, seen_q);
		a_col  = scol_q;
		a_off  = soff_q;
		a_len  = len_q;
		emit_b = 1'b0;
		b_kind = item.bkind;
		b_col  = col_q;
		b_off  = byte_q;
		b_len  = LEN_W'(1);

		case (mode_q)
			MODE_COMMENT: begin
				if (item.cls == stt_pkg::CLS_NEWLINE) begin
					mode_d = MODE_IDLE;
					nl     = 1'b1;
				end
			end
			MODE_IDENT: begin
				if (item.cls == stt_pkg::CLS_LETTER) begin
					len_d = ext_len;
					pfx_d = ext_pfx;
				end else begin
					emit_a  = 1'b1;
					mode_d  = MODE_IDLE;
					as_idle = 1'b1;
				end
			end
			MODE_NUMBER: begin
				if (item.cls == stt_pkg::CLS_DIGIT) begin
					len_d = ext_len;
					pfx_d = ext_pfx;
				end else if (item.cls == stt_pkg::CLS_DOT) begin
					len_d = ext_len;
					pfx_d = ext_pfx;
					if (seen_q) begin
						// second dot: report and halt until end of source
						emit_a = 1'b1;
						a_kind = stt_pkg::KIND_ERROR;
						a_len  = ext_len;
						mode_d = MODE_HALTED;
					end else begin
						seen_d = 1'b1;
					end
				end else begin
					emit_a  = 1'b1;
					mode_d  = MODE_IDLE;
					as_idle = 1'b1;
				end
			end
			MODE_IDLE: as_idle = 1'b1;
			default: ;
		endcase

		if (as_idle) begin
			case (item.cls)
				stt_pkg::CLS_NEWLINE: nl = 1'b1;
				stt_pkg::CLS_HASH:    mode_d = MODE_COMMENT;
				stt_pkg::CLS_LETTER:  start_ident = 1'b1;
				stt_pkg::CLS_DIGIT:   start_number = 1'b1;
				stt_pkg::CLS_BRACKET: emit_b = 1'b1;
				default: ;
			endcase
		end

		if (start_ident || start_number) begin
			mode_d = start_ident ? MODE_IDENT : MODE_NUMBER;
			seen_d = 1'b0;
			scol_d = col_q;
			soff_d = byte_q;
			len_d  = LEN_W'(1);
			pfx_d  = PFX_W'(item.ch);
		end

		if (nl) begin
			line_d = (&line_q) ? line_q : line_q + 1'b1;
			col_d  = '0;
		end else begin
			line_d = line_q;
			col_d  = (&col_q) ? col_q : col_q + 1'b1;
		end
		byte_d = (&byte_q) ? byte_q : byte_q + 1'b1;

		if (item.last) begin
			// flush a pending run, then return to reset values
			if (mode_d == MODE_IDENT || mode_d == MODE_NUMBER) begin
				emit_b = 1'b1;
				b_kind = run_kind(mode_d, len_d, pfx_d, seen_d);
				b_col  = scol_d;
				b_off  = soff_d;
				b_len  = len_d;
			end
			mode_d = MODE_IDLE;
			seen_d = 1'b0;
			line_d = LINE_BITS'(1);
			col_d  = '0;
			byte_d = '0;
			scol_d = '0;
			soff_d = '0;
			len_d  = '0;
			pfx_d  = '0;
		end
	end

	assign line_w  = 32'(line_q);
	assign a_col_w = 32'(a_col);
	assign b_col_w = 32'(b_col);
	assign a_off_w = 48'(a_off);
	assign b_off_w = 48'(b_off);

	always_comb begin
		stt_pkg::token_t ta;
		stt_pkg::token_t tb;
		ta.kind        = a_kind;
		ta.line        = line_w[stt_pkg::LINE_W-1:0];
		ta.column      = a_col_w[stt_pkg::COLUMN_W-1:0];
		ta.offset      = a_off_w[stt_pkg::OFFSET_W-1:0];
		ta.length      = a_len;
		ta.last_of_run = !emit_b;
		tb.kind        = b_kind;
		tb.line        = line_w[stt_pkg::LINE_W-1:0];
		tb.column      = b_col_w[stt_pkg::COLUMN_W-1:0];
		tb.offset      = b_off_w[stt_pkg::OFFSET_W-1:0];
		tb.length      = b_len;
		tb.last_of_run = 1'b1;
		wr.tok0  = emit_a ? ta : tb;
		wr.tok1  = tb;
		wr.count = fire ? (2'(emit_a) + 2'(emit_b)) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			seen_q <= 1'b0;
			line_q <= LINE_BITS'(1);
			col_q  <= '0;
			byte_q <= '0;
			scol_q <= '0;
			soff_q <= '0;
			len_q  <= '0;
			pfx_q  <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			seen_q <= seen_d;
			line_q <= line_d;
			col_q  <= col_d;
			byte_q <= byte_d;
			scol_q <= scol_d;
			soff_q <= soff_d;
			len_q  <= len_d;
			pfx_q  <= pfx_d;
		end
	end

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.last |=> mode_q == MODE_IDLE && line_q == LINE_BITS'(1) && byte_q == '0)
		else $error("end of source did not return the scanner to reset");

	a_two_need_run: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit_a && emit_b |-> mode_q == MODE_IDENT || mode_q == MODE_NUMBER)
		else $error("two tokens from one byte without a pending run");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_HALTED |-> !emit_a && !emit_b)
		else $error("token emitted while halted");

endmodule

FILE: design/stt_outq.sv
module stt_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  stt_pkg::res_wr_t wr,
	output logic             room,
	output logic             empty,
	input  logic             pop,
	output stt_pkg::token_t  head
);

	localparam int PTR_W = $clog2(stt_pkg::OUT_DEPTH);
	localparam int CNT_W = $clog2(stt_pkg::OUT_DEPTH + 1);

	stt_pkg::token_t  slot_q [stt_pkg::OUT_DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] wp_next;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign empty   = (cnt_q == '0);
	assign room    = (cnt_q <= CNT_W'(stt_pkg::OUT_DEPTH - 2));
	assign head    = slot_q[rp_q];
	assign do_pop  = pop && !empty;
	assign wp_next = wp_q + 1'b1;

	always_ff @(posedge clk) begin
		if (wr.count != 2'd0) begin
			slot_q[wp_q] <= wr.tok0;
		end
		if (wr.count == 2'd2) begin
			slot_q[wp_next] <= wr.tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PTR_W'(wr.count);
			rp_q  <= rp_q + PTR_W'(do_pop);
			cnt_q <= cnt_q + CNT_W'(wr.count) - CNT_W'(do_pop);
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		wr.count == 2'd2 |-> cnt_q <= CNT_W'(stt_pkg::OUT_DEPTH - 2))
		else $error("pair written into result queue without room");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(stt_pkg::OUT_DEPTH))
		else $error("result queue count beyond depth");

endmodule

FILE: design/source_text_tokenizer_core.sv
// Channel   Handshake            Payload
// input     push / full          ch, end_of_source
// result    pop / empty          token_kind, line, column, offset, token_length, last_of_run
//
// One byte per cycle sustained while the result queue has room: the classifier registers each byte into a two-entry
// queue, and the scanner retires one queued byte per cycle into a four-entry result
// queue, writing up to two tokens at once.
// A byte is registered in the input queue, and its tokens in the result queue, which drives the result ports.
// The scanner stalls only when fewer than two result slots are free; full then follows.
// Reset (arst_n low) clears all queues and puts the scanner at line 1, column 0.
module source_text_tokenizer_core #(
	parameter int LINE_BITS   = 16,
	parameter int COLUMN_BITS = 16,
	parameter int OFFSET_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [stt_pkg::CH_BITS-1:0]         ch,
	input  logic                                end_of_source,
	output logic                                empty,
	input  logic                                pop,
	output logic [stt_pkg::KIND_BITS-1:0]       token_kind,
	output logic [stt_pkg::LINE_W-1:0]          line,
	output logic [stt_pkg::COLUMN_W-1:0]        column,
	output logic [stt_pkg::OFFSET_W-1:0]        offset,
	output logic [stt_pkg::LENGTH_W-1:0]        token_length,
	output logic                                last_of_run
);

	// classified item between front and scanner
	logic             item_valid;
	logic             item_take;
	stt_pkg::item_t   item;

	// scanner writes into the result queue
	logic             room;
	stt_pkg::res_wr_t wr;
	stt_pkg::token_t  head;

	// Front: classify each byte and hold it until the scanner takes it.
	stt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.ch            (ch),
		.end_of_source (end_of_source),
		.item_valid    (item_valid),
		.item          (item),
		.item_take     (item_take)
	);

	// Back: advance the scan state and emit tokens with their positions.
	stt_back #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.room       (room),
		.wr         (wr)
	);

	// Result queue: hold tokens until the consumer pops them.
	stt_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.room   (room),
		.empty  (empty),
		.pop    (pop),
		.head   (head)
	);

	assign token_kind   = head.kind;
	assign line         = head.line;
	assign column       = head.column;
	assign offset       = head.offset;
	assign token_length = head.length;
	assign last_of_run  = head.last_of_run;

endmodule

FILE: bench/token_stream_monitor.sv
`timescale 1ns / 100ps

module token_stream_monitor
	import stt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  logic [CH_BITS-1:0]   ch,
	input  logic                 end_of_source,
	input  logic                 empty,
	input  logic                 pop,
	input  logic [KIND_BITS-1:0] token_kind,
	input  logic [LINE_W-1:0]    line,
	input  logic [COLUMN_W-1:0]  column,
	input  logic [OFFSET_W-1:0]  offset,
	input  logic [LENGTH_W-1:0]  token_length,
	input  logic                 last_of_run,
	output int                   failures,
	output int                   outstanding,
	output int                   tokens_checked
);

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_IDENT,
		SCAN_NUMBER,
		SCAN_COMMENT,
		SCAN_HALTED
	} scan_mode_t;

	scan_mode_t             mode;
	logic                   has_point;
	logic [LINE_W-1:0]      cur_line;
	logic [COLUMN_W-1:0]    cur_col;
	logic [OFFSET_W-1:0]    cur_off;
	logic [COLUMN_W-1:0]    run_col;
	logic [OFFSET_W-1:0]    run_off;
	logic [LENGTH_W-1:0]    run_len;
	logic [PREFIX_BITS-1:0] prefix;

	token_t expected_tokens[$];

	function automatic logic is_alpha(input logic [CH_BITS-1:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_num(input logic [CH_BITS-1:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// KIND_IDENT doubles as "not a bracket"
	function automatic logic [KIND_BITS-1:0] bracket_of(input logic [CH_BITS-1:0] c);
		case (c)
			"(":     return KIND_LPAREN;
			")":     return KIND_RPAREN;
			"{":     return KIND_LBRACE;
			"}":     return KIND_RBRACE;
			"[":     return KIND_LBRACK;
			"]":     return KIND_RBRACK;
			";":     return KIND_SEMI;
			default: return KIND_IDENT;
		endcase
	endfunction

	function automatic token_t make_token(input logic [KIND_BITS-1:0] kind,
			input logic [COLUMN_W-1:0] col, input logic [OFFSET_W-1:0] off,
			input logic [LENGTH_W-1:0] len);
		token_t t;
		t.kind        = kind;
		t.line        = cur_line;
		t.column      = col;
		t.offset      = off;
		t.length      = len;
		t.last_of_run = 1'b0;
		return t;
	endfunction

	function automatic token_t run_token();
		logic [KIND_BITS-1:0] kind;
		if (mode == SCAN_IDENT) begin
			kind = KIND_IDENT;
			if ((run_len == 3 && prefix == WORD_INT) || (run_len == 5 && prefix == WORD_FLOAT))
				kind = KIND_KEYWORD;
		end else begin
			kind = has_point ? KIND_FLOAT : KIND_INT;
		end
		return make_token(kind, run_col, run_off, run_len);
	endfunction

	task automatic clear_state();
		mode      = SCAN_IDLE;
		has_point = 1'b0;
		cur_line  = LINE_W'(1);
		cur_col   = '0;
		cur_off   = '0;
		run_col   = '0;
		run_off   = '0;
		run_len   = '0;
		prefix    = '0;
	endtask

	task automatic open_run(input scan_mode_t m, input logic [CH_BITS-1:0] c);
		mode      = m;
		has_point = 1'b0;
		run_col   = cur_col;
		run_off   = cur_off;
		run_len   = LENGTH_W'(1);
		prefix    = {{(PREFIX_BITS-CH_BITS){1'b0}}, c};
	endtask

	task automatic grow_run(input logic [CH_BITS-1:0] c);
		if (run_len < 5)
			prefix = {prefix[PREFIX_BITS-CH_BITS-1:0], c};
		if (run_len != '1)
			run_len++;
	endtask

	task automatic predict_byte(input logic [CH_BITS-1:0] c, input logic eos);
		token_t               step_tokens[$];
		logic                 newline;
		logic                 as_idle;
		logic [KIND_BITS-1:0] bk;
		newline = 1'b0;
		as_idle = 1'b0;
		case (mode)
			SCAN_COMMENT: begin
				if (c == CH_NEWLINE) begin
					mode    = SCAN_IDLE;
					newline = 1'b1;
				end
			end
			SCAN_IDENT: begin
				if (is_alpha(c)) begin
					grow_run(c);
				end else begin
					step_tokens.insert(step_tokens.size(), run_token());
					mode    = SCAN_IDLE;
					as_idle = 1'b1;
				end
			end
			SCAN_NUMBER: begin
				if (is_num(c)) begin
					grow_run(c);
				end else if (c == CH_DOT) begin
					grow_run(c);
					if (has_point) begin
						step_tokens.insert(step_tokens.size(),
							make_token(KIND_ERROR, run_col, run_off, run_len));
						mode = SCAN_HALTED;
					end else begin
						has_point = 1'b1;
					end
				end else begin
					step_tokens.insert(step_tokens.size(), run_token());
					mode    = SCAN_IDLE;
					as_idle = 1'b1;
				end
			end
			SCAN_IDLE: as_idle = 1'b1;
			default: ;
		endcase

		if (as_idle) begin
			bk = bracket_of(c);
			if (c == CH_NEWLINE)
				newline = 1'b1;
			else if (c == CH_HASH)
				mode = SCAN_COMMENT;
			else if (is_alpha(c))
				open_run(SCAN_IDENT, c);
			else if (is_num(c))
				open_run(SCAN_NUMBER, c);
			else if (bk != KIND_IDENT)
				step_tokens.insert(step_tokens.size(),
					make_token(bk, cur_col, cur_off, LENGTH_W'(1)));
		end

		if (newline) begin
			if (cur_line != '1)
				cur_line++;
			cur_col = '0;
		end else if (cur_col != '1) begin
			cur_col++;
		end
		if (cur_off != '1)
			cur_off++;

		if (eos) begin
			if (mode == SCAN_IDENT || mode == SCAN_NUMBER)
				step_tokens.insert(step_tokens.size(), run_token());
			clear_state();
		end

		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
		foreach (step_tokens[i])
			expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
	endtask

	task automatic check_field(input string name, input logic [OFFSET_W-1:0] want,
			input logic [OFFSET_W-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		token_t want;
		if (!arst_n) begin
			clear_state();
			expected_tokens.delete();
			failures       = 0;
			tokens_checked = 0;
		end else begin
			if (push && !full)
				predict_byte(ch, end_of_source);
			if (pop && !empty) begin
				if (expected_tokens.size() == 0) begin
					$error("unexpected token: kind %0d line %0d column %0d offset %0d",
						token_kind, line, column, offset);
					failures++;
				end else begin
					want = expected_tokens.pop_front();
					check_field("token_kind", OFFSET_W'(want.kind), OFFSET_W'(token_kind));
					check_field("line", OFFSET_W'(want.line), OFFSET_W'(line));
					check_field("column", OFFSET_W'(want.column), OFFSET_W'(column));
					check_field("offset", want.offset, offset);
					check_field("token_length", OFFSET_W'(want.length),
						OFFSET_W'(token_length));
					check_field("last_of_run", OFFSET_W'(want.last_of_run),
						OFFSET_W'(last_of_run));
					tokens_checked++;
				end
			end
		end
		outstanding = expected_tokens.size();
	end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import stt_pkg::*;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 push          = 1'b0;
	logic [CH_BITS-1:0]   ch            = '0;
	logic                 end_of_source = 1'b0;
	logic                 pop           = 1'b0;
	logic                 full;
	logic                 empty;
	logic [KIND_BITS-1:0] token_kind;
	logic [LINE_W-1:0]    line;
	logic [COLUMN_W-1:0]  column;
	logic [OFFSET_W-1:0]  offset;
	logic [LENGTH_W-1:0]  token_length;
	logic                 last_of_run;

	int failures;
	int outstanding;
	int tokens_checked;

	// source text waiting to go out, and run statistics
	logic [CH_BITS-1:0] source_bytes[$];
	int                 bytes_sent;
	int                 random_bytes;
	int                 sources_sent;
	// when set, neither side idles
	bit                 calm;

	always #10 clk = ~clk;

	source_text_tokenizer_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.ch           (ch),
		.end_of_source(end_of_source),
		.empty        (empty),
		.pop          (pop),
		.token_kind   (token_kind),
		.line         (line),
		.column       (column),
		.offset       (offset),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	token_stream_monitor i_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.ch            (ch),
		.end_of_source (end_of_source),
		.empty         (empty),
		.pop           (pop),
		.token_kind    (token_kind),
		.line          (line),
		.column        (column),
		.offset        (offset),
		.token_length  (token_length),
		.last_of_run   (last_of_run),
		.failures      (failures),
		.outstanding   (outstanding),
		.tokens_checked(tokens_checked)
	);

	// Result side: stall pop with a chance of about 23 in 100, never while calm.
	always @(negedge clk) begin
		pop <= calm || ($urandom_range(0, 99) >= 23);
	end

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#40_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Offer one byte at the falling edge and hold it until a rising edge sees full low.
	// Push stays high between back-to-back items, so it is never lowered and raised
	// in the same step.
	task automatic send_byte(input logic [CH_BITS-1:0] c, input logic last);
		while (!calm && $urandom_range(0, 99) < 23) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push          <= 1'b1;
		ch            <= c;
		end_of_source <= last;
		@(posedge clk);
		while (full)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Drain the pending text as one source; mark its final byte as the end.
	task automatic send_source();
		foreach (source_bytes[i])
			send_byte(source_bytes[i], i == source_bytes.size() - 1);
		source_bytes.delete();
		sources_sent++;
	endtask

	task automatic append_byte(input logic [CH_BITS-1:0] c);
		source_bytes.insert(source_bytes.size(), c);
	endtask

	task automatic load_text(input string s);
		for (int i = 0; i < s.len(); i++)
			append_byte(s[i]);
	endtask

	function automatic logic [CH_BITS-1:0] any_letter();
		logic [CH_BITS-1:0] c;
		c = CH_BITS'($urandom_range(0, 25));
		return $urandom_range(0, 1) ? "a" + c : "A" + c;
	endfunction

	function automatic logic [CH_BITS-1:0] any_digit();
		return "0" + CH_BITS'($urandom_range(0, 9));
	endfunction

	// Build one random source: mostly well-formed lexemes with random content,
	// plus some comments, stray bytes and broken numbers.
	task automatic make_random_source();
		string words[9];
		string marks;
		int    target;
		int    pick;
		int    n;
		words  = '{"int", "float", "in", "intt", "floa", "floats", "Int", "FLOAT", "fl"};
		marks  = "(){}[];";
		target = $urandom_range(4, 40);
		while (source_bytes.size() < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				// identifier, sometimes a keyword or a near miss
				if ($urandom_range(0, 2) == 0) begin
					load_text(words[$urandom_range(0, 8)]);
				end else begin
					n = $urandom_range(1, 8);
					repeat (n) append_byte(any_letter());
				end
			end else if (pick < 55) begin
				// number: integer, float, or a broken one with a second dot
				n = $urandom_range(1, 5);
				repeat (n) append_byte(any_digit());
				if ($urandom_range(0, 9) < 7) begin
					append_byte(CH_DOT);
					n = $urandom_range(0, 3);
					repeat (n) append_byte(any_digit());
					if ($urandom_range(0, 99) < 8) begin
						append_byte(CH_DOT);
						n = $urandom_range(0, 2);
						repeat (n) append_byte(any_digit());
					end
				end
			end else if (pick < 70) begin
				append_byte(marks[$urandom_range(0, 6)]);
			end else if (pick < 82) begin
				case ($urandom_range(0, 2))
					0:       append_byte(CH_SPACE);
					1:       append_byte(CH_TAB);
					default: append_byte(CH_NEWLINE);
				endcase
			end else if (pick < 88) begin
				// comment; now and then left open to the end of the source
				append_byte(CH_HASH);
				n = $urandom_range(0, 6);
				repeat (n) append_byte(CH_BITS'($urandom_range(11, 255)));
				if ($urandom_range(0, 4) != 0)
					append_byte(CH_NEWLINE);
			end else begin
				// raw noise over the whole byte range
				n = $urandom_range(1, 3);
				repeat (n) append_byte(CH_BITS'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		bytes_sent   = 0;
		random_bytes = 0;
		sources_sent = 0;
		calm         = 1'b0;

		// Hold reset low, then release it at a falling edge.
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed sources.
		// Keyword, int and identifier each closed by a bracket in the same step.
		load_text("int(9;x]");
		send_source();
		// Comment hides a brace, then a high byte, a stray dot, and a second dot
		// that halts the scan; the trailing paren must be ignored.
		load_text("#{\n");
		append_byte(8'hFF);
		load_text(".1.5.)");
		send_source();
		// Float closed by a brace; the keyword is flushed by the end of the source.
		load_text("\t2.5{float");
		send_source();
		load_text("}[)");
		send_source();

		// Random sources; leave a long stretch with no idling on either side.
		while (random_bytes < 1050) begin
			calm = (random_bytes > 350 && random_bytes < 600);
			random_bytes += source_bytes.size();
			make_random_source();
			random_bytes += source_bytes.size();
			send_source();
		end
		calm = 1'b0;

		// Release push, drain every expected token, then watch for strays.
		@(negedge clk);
		push <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d bytes in %0d sources, with random gaps on both sides",
			bytes_sent, sources_sent);
		$display("Compared %0d tokens with the prediction, %0d mismatches",
			tokens_checked, failures);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: sim.f
design/stt_pkg.sv
design/stt_front.sv
design/stt_back.sv
design/stt_outq.sv
design/source_text_tokenizer_core.sv
bench/token_stream_monitor.sv
bench/tb.sv
